// ===== rtl/core/crt_pkg.sv =====
`default_nettype none

package crt_pkg;

  localparam int DEF_ENTRIES  = 8;
  localparam int DEF_TAG_BITS = 32;

  localparam int IN_TAG_W  = 32;
  localparam int OUT_SLOT_W = 3;
  localparam int LFSR_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int POLICY_W  = 2;
  localparam int ACTIVE_W  = 4;

  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

  localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FIFO   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LRU    = 2'd2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic hit_upd;
    logic fill;
    logic pick;
    logic div_start;
    logic evict;
  } crt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic room;
    logic rand_mode;
    logic div_done;
  } crt_stat_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_MASK;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crt_mod.sv =====
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module crt_mod #(
  parameter int ENTRIES = crt_pkg::DEF_ENTRIES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [crt_pkg::LFSR_W-1:0]  dividend,
  input  wire logic [$clog2(ENTRIES+1)-1:0] divisor,
  output logic                             done,
  output logic [$clog2(ENTRIES)-1:0]       rem
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(ENTRIES);
  localparam int NW = $clog2(crt_pkg::LFSR_W);
  localparam logic [NW-1:0] LAST_BIT = NW'(crt_pkg::LFSR_W - 1);

  logic                       run_r;
  logic                       done_r;
  logic [NW-1:0]              cnt_r;
  logic [crt_pkg::LFSR_W-1:0] shift_r;
  logic [CW-1:0]              div_r;
  logic [CW-1:0]              rem_r;
  logic [CW:0]                trial;
  logic [CW-1:0]              rem_nxt;

  always_comb begin
    trial = {rem_r, shift_r[crt_pkg::LFSR_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CW'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      div_r   <= divisor;
      rem_r   <= '0;
      cnt_r   <= LAST_BIT;
    end else if (run_r) begin
      shift_r <= shift_r << 1;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_r - NW'(1);
    end
  end

  assign done = done_r;
  assign rem  = rem_r[SW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/crt_datapath.sv =====
`default_nettype none

module crt_datapath #(
  parameter int ENTRIES  = crt_pkg::DEF_ENTRIES,
  parameter int TAG_BITS = crt_pkg::DEF_TAG_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire crt_pkg::crt_cmd_t              cmd,
  output crt_pkg::crt_stat_t                  stat,
  input  wire logic [crt_pkg::IN_TAG_W-1:0]   in_block_tag,
  input  wire logic                           cfg_we,
  input  wire logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crt_pkg::CFG_DAT_W-1:0]  cfg_data,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [crt_pkg::OUT_SLOT_W-1:0]      out_slot,
  output logic                                out_evicted,
  output logic [crt_pkg::IN_TAG_W-1:0]        out_victim_tag
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > crt_pkg::ACTIVE_W) ? CW : crt_pkg::ACTIVE_W;
  localparam int TW = (TAG_BITS > crt_pkg::IN_TAG_W) ? TAG_BITS : crt_pkg::IN_TAG_W;

  // Configuration registers.
  logic [crt_pkg::POLICY_W-1:0] policy_r;
  logic [crt_pkg::ACTIVE_W-1:0] active_r;
  logic [crt_pkg::LFSR_W-1:0]   lfsr_r;

  // Store.
  logic [TAG_BITS-1:0] tag_r  [ENTRIES];
  logic [SW-1:0]       rank_r [ENTRIES];
  logic [SW-1:0]       rank_nxt [ENTRIES];
  logic [CW-1:0]       fill_r;

  logic [TAG_BITS-1:0] key_r;
  logic [ENTRIES-1:0]  match_r;
  logic [ENTRIES-1:0]  valid;
  logic [SW-1:0]       vslot_r;

  logic [TW-1:0]       in_ext;
  logic [TW-1:0]       victim_ext;
  logic [SW-1:0]       hit_slot;
  logic [SW-1:0]       pick_slot;
  logic [SW-1:0]       fill_slot;
  logic [SW-1:0]       upd_slot;
  logic [SW-1:0]       upd_lim;
  logic                upd_en;
  logic [CW-1:0]       fill_m1;
  logic [LW-1:0]       active_ext;
  logic [LW-1:0]       limit;
  logic                lru_mode;
  logic [crt_pkg::LFSR_W-1:0] lfsr_step;
  logic                mod_done;
  logic [SW-1:0]       mod_rem;

  assign in_ext     = TW'(in_block_tag);
  assign lru_mode   = policy_r[1];
  assign lfsr_step  = crt_pkg::lfsr_next(lfsr_r);
  assign fill_slot  = fill_r[SW-1:0];
  assign fill_m1    = fill_r - CW'(1);
  assign active_ext = LW'(active_r);

  // Zero behaves as one, and anything above the store size as the store size.
  always_comb begin
    if (active_r == '0) begin
      limit = LW'(1);
    end else if (active_ext > LW'(ENTRIES)) begin
      limit = LW'(ENTRIES);
    end else begin
      limit = active_ext;
    end
  end

  always_comb begin
    hit_slot  = '0;
    pick_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i] = CW'(i) < fill_r;
      if (match_r[i]) begin
        hit_slot = hit_slot | SW'(i);
      end
      if (valid[i] && rank_r[i] == fill_m1[SW-1:0]) begin
        pick_slot = pick_slot | SW'(i);
      end
    end
  end

  always_comb begin
    stat.hit       = |match_r;
    stat.room      = LW'(fill_r) < limit;
    stat.rand_mode = policy_r == crt_pkg::POL_RANDOM;
    stat.div_done  = mod_done;
  end

  // Moving an entry to rank zero: held entries younger than its old rank
  // age by one; on a fill every held entry ages.
  always_comb begin
    upd_en = (cmd.hit_upd && lru_mode) || cmd.fill || cmd.evict;
    if (cmd.fill) begin
      upd_slot = fill_slot;
    end else if (cmd.evict) begin
      upd_slot = vslot_r;
    end else begin
      upd_slot = hit_slot;
    end
    upd_lim = rank_r[upd_slot];
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (upd_en && valid[i] && SW'(i) != upd_slot &&
          (cmd.fill || rank_r[i] < upd_lim)) begin
        rank_nxt[i] = rank_r[i] + SW'(1);
      end
    end
    if (upd_en) begin
      rank_nxt[upd_slot] = '0;
    end
  end

  crt_mod #(
    .ENTRIES (ENTRIES)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lfsr_step),
    .divisor  (fill_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= crt_pkg::POL_LRU;
      active_r  <= crt_pkg::ACTIVE_RESET;
      lfsr_r    <= crt_pkg::LFSR_ONE;
      fill_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.hit_upd || cmd.fill || cmd.evict;
      if (cfg_we) begin
        case (cfg_index)
          crt_pkg::CFG_POLICY: policy_r <= cfg_data[crt_pkg::POLICY_W-1:0];
          crt_pkg::CFG_ACTIVE: active_r <= cfg_data[crt_pkg::ACTIVE_W-1:0];
          crt_pkg::CFG_SEED: begin
            lfsr_r <= (cfg_data == '0) ? crt_pkg::LFSR_ONE : cfg_data;
          end
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        lfsr_r <= lfsr_step;
      end
      if (cmd.fill) begin
        fill_r <= fill_r + CW'(1);
      end
    end
  end

  assign victim_ext = TW'(tag_r[vslot_r]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_ext[TAG_BITS-1:0];
    end
    if (cmd.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_r[i] <= valid[i] && tag_r[i] == key_r;
      end
    end
    if (cmd.pick) begin
      vslot_r <= pick_slot;
    end else if (mod_done) begin
      vslot_r <= mod_rem;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      rank_r[i] <= rank_nxt[i];
    end
    if (cmd.fill) begin
      tag_r[fill_slot] <= key_r;
    end else if (cmd.evict) begin
      tag_r[vslot_r] <= key_r;
    end
    if (cmd.hit_upd) begin
      out_hit        <= 1'b1;
      out_slot       <= crt_pkg::OUT_SLOT_W'(hit_slot);
      out_evicted    <= 1'b0;
      out_victim_tag <= '0;
    end else if (cmd.fill) begin
      out_hit        <= 1'b0;
      out_slot       <= crt_pkg::OUT_SLOT_W'(fill_slot);
      out_evicted    <= 1'b0;
      out_victim_tag <= '0;
    end else if (cmd.evict) begin
      out_hit        <= 1'b0;
      out_slot       <= crt_pkg::OUT_SLOT_W'(vslot_r);
      out_evicted    <= 1'b1;
      out_victim_tag <= victim_ext[crt_pkg::IN_TAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crt_ctrl.sv =====
`default_nettype none

module crt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire crt_pkg::crt_stat_t stat,
  output crt_pkg::crt_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_DIVIDE,
    ST_EVICT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (stat.hit) begin
          cmd.hit_upd = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (stat.room) begin
          cmd.fill  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.rand_mode) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end else begin
          cmd.pick  = 1'b1;
          state_nxt = ST_EVICT;
        end
      end
      ST_DIVIDE: begin
        if (stat.div_done) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != ST_IDLE;
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== rtl/core/cache_replacement_tracker.sv =====
// After the accepting edge, a lookup passes the match and resolve states; hits and
// fills end there, FIFO and LRU evictions add the evict state, and random evictions
// add the 16-step remainder unit (LFSR value modulo fill count, one bit per cycle)
// and then the evict state. A new item is taken only once busy drops with the result.
// Synchronous reset empties the store and restores the configuration defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module cache_replacement_tracker #(
  parameter int ENTRIES  = crt_pkg::DEF_ENTRIES,
  parameter int TAG_BITS = crt_pkg::DEF_TAG_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [crt_pkg::IN_TAG_W-1:0]  in_block_tag,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [crt_pkg::OUT_SLOT_W-1:0]     out_slot,
  output logic                               out_evicted,
  output logic [crt_pkg::IN_TAG_W-1:0]       out_victim_tag,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [crt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crt_pkg::CFG_DAT_W-1:0] cfg_data
);

  crt_pkg::crt_cmd_t  cmd;
  crt_pkg::crt_stat_t stat;

  assign cfg_ready = 1'b1;

  crt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  crt_datapath #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_block_tag   (in_block_tag),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted),
    .out_victim_tag (out_victim_tag)
  );

endmodule

`default_nettype wire

// ===== dv/tb_cache_replacement_tracker.sv =====
`default_nettype none

module tb_cache_replacement_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS     = crt_pkg::DEF_ENTRIES;
  localparam int TAG_W         = crt_pkg::IN_TAG_W;
  localparam int SLOT_W        = crt_pkg::OUT_SLOT_W;
  localparam int DAT_W         = crt_pkg::CFG_DAT_W;
  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 30;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 250;
  localparam int PRINT_CAP     = 50;

  // Index 3 has no register behind it, and policy code 3 behaves as LRU.
  localparam logic [crt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [crt_pkg::POLICY_W-1:0]  POL_SPARE = 2'd3;

  typedef enum logic [1:0] {
    OP_ACCESS,
    OP_CONFIG,
    OP_QUIESCE
  } stim_kind_t;

  typedef struct {
    stim_kind_t                      kind;
    logic [crt_pkg::IN_TAG_W-1:0]    tag;
    logic [crt_pkg::CFG_IDX_W-1:0]   index;
    logic [crt_pkg::CFG_DAT_W-1:0]   data;
  } stim_t;

  typedef struct packed {
    logic                           hit;
    logic [crt_pkg::OUT_SLOT_W-1:0] slot;
    logic                           evicted;
    logic [crt_pkg::IN_TAG_W-1:0]   victim_tag;
  } lookup_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [crt_pkg::IN_TAG_W-1:0]   in_block_tag;
  logic                           out_valid;
  logic                           out_hit;
  logic [crt_pkg::OUT_SLOT_W-1:0] out_slot;
  logic                           out_evicted;
  logic [crt_pkg::IN_TAG_W-1:0]   out_victim_tag;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [crt_pkg::CFG_DAT_W-1:0]  cfg_data;

  cache_replacement_tracker uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_block_tag   (in_block_tag),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted),
    .out_victim_tag (out_victim_tag),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Shadow copy of the tracker state.
  logic [crt_pkg::POLICY_W-1:0] policy_reg;
  logic [crt_pkg::ACTIVE_W-1:0] active_reg;
  logic [crt_pkg::LFSR_W-1:0]   lfsr_reg;
  logic [crt_pkg::IN_TAG_W-1:0] held_tag [NUM_SLOTS];
  logic [2:0]                   rank [NUM_SLOTS];
  logic [3:0]                   held_count;

  stim_t          pending[$];
  lookup_result_t expected_lookups[$];
  stim_t          cur;
  lookup_result_t oldest;
  logic           drv_active;
  int             hold_cycles;
  logic           tag_taken;
  logic           cfg_taken;
  int             tags_taken;
  int             quiet_cycles;
  int             errors;

  task automatic report_mismatch(input string what, input logic [crt_pkg::IN_TAG_W-1:0] got,
                                 input logic [crt_pkg::IN_TAG_W-1:0] want);
    if (errors < PRINT_CAP) begin
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Slot s becomes rank 0; every held slot ranked below limit ages by one.
  function automatic void age_up(input int s, input int limit);
    for (int i = 0; i < held_count; i++) begin
      if (i != s && rank[i] < limit) begin
        rank[i]++;
      end
    end
    rank[s] = '0;
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [crt_pkg::IN_TAG_W-1:0] tag);
    lookup_result_t               r;
    int                           cap;
    logic [crt_pkg::POLICY_W-1:0] mode;
    int                           s;
    r = '0;
    cap = (active_reg == 0) ? 1 : ((active_reg > NUM_SLOTS) ? NUM_SLOTS : int'(active_reg));
    mode = (policy_reg == POL_SPARE) ? crt_pkg::POL_LRU : policy_reg;
    for (int i = 0; i < held_count; i++) begin
      if (held_tag[i] == tag) begin
        if (mode == crt_pkg::POL_LRU) begin
          age_up(i, int'(rank[i]));
        end
        r.hit = 1'b1;
        r.slot = SLOT_W'(i);
        return r;
      end
    end
    if (held_count < cap) begin
      s = int'(held_count);
      held_tag[s] = tag;
      held_count++;
      age_up(s, int'(held_count));
      r.slot = SLOT_W'(s);
      return r;
    end
    s = 0;
    if (mode == crt_pkg::POL_RANDOM) begin
      lfsr_reg = {1'b0, lfsr_reg[crt_pkg::LFSR_W-1:1]} ^
                 (lfsr_reg[0] ? crt_pkg::LFSR_MASK : '0);
      s = int'(lfsr_reg % held_count);
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (rank[i] == held_count - 1) begin
          s = i;
        end
      end
    end
    r.victim_tag = held_tag[s];
    held_tag[s] = tag;
    age_up(s, int'(rank[s]));
    r.evicted = 1'b1;
    r.slot = SLOT_W'(s);
    return r;
  endfunction

  task automatic add_access(input logic [crt_pkg::IN_TAG_W-1:0] tag);
    stim_t st;
    st = '{kind: OP_ACCESS, tag: tag, index: '0, data: '0};
    pending.push_back(st);
  endtask

  task automatic add_write(input logic [crt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [crt_pkg::CFG_DAT_W-1:0] data);
    stim_t st;
    st = '{kind: OP_CONFIG, tag: '0, index: idx, data: data};
    pending.push_back(st);
  endtask

  // Holds the sender until every outstanding lookup has reported.
  task automatic add_quiesce();
    stim_t st;
    st = '{kind: OP_QUIESCE, tag: '0, index: '0, data: '0};
    pending.push_back(st);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_block_tag = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      drv_active = 1'b0;
      hold_cycles = 0;
    end else begin
      if (drv_active && (tag_taken || cfg_taken)) begin
        drv_active = 1'b0;
      end
      if (!drv_active) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else if (pending.size() > 0) begin
          if (pending[0].kind == OP_QUIESCE) begin
            if (expected_lookups.size() == 0) begin
              pending.delete(0);
              hold_cycles = SETTLE_CYCLES;
            end
          end else if ((tags_taken >= 700 && tags_taken < 1000) ||
                       $urandom_range(99) >= IDLE_PCT) begin
            cur = pending.pop_front();
            drv_active = 1'b1;
          end
        end
      end
      start <= drv_active && cur.kind == OP_ACCESS;
      cfg_valid <= drv_active && cur.kind == OP_CONFIG;
      in_block_tag <= cur.tag;
      cfg_index <= cur.index;
      cfg_data <= cur.data;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      tag_taken <= 1'b0;
      cfg_taken <= 1'b0;
      tags_taken <= 0;
      quiet_cycles <= 0;
      policy_reg = crt_pkg::POL_LRU;
      active_reg = crt_pkg::ACTIVE_RESET;
      lfsr_reg = crt_pkg::LFSR_ONE;
      held_count = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        held_tag[i] = '0;
        rank[i] = '0;
      end
    end else begin
      tag_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if (out_valid) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected result, victim_tag", out_victim_tag, '0);
        end else begin
          oldest = expected_lookups.pop_front();
          if (out_hit !== oldest.hit) begin
            report_mismatch("hit", TAG_W'(out_hit), TAG_W'(oldest.hit));
          end
          if (out_slot !== oldest.slot) begin
            report_mismatch("slot", TAG_W'(out_slot), TAG_W'(oldest.slot));
          end
          if (out_evicted !== oldest.evicted) begin
            report_mismatch("evicted", TAG_W'(out_evicted), TAG_W'(oldest.evicted));
          end
          if (out_victim_tag !== oldest.victim_tag) begin
            report_mismatch("victim_tag", out_victim_tag, oldest.victim_tag);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crt_pkg::CFG_POLICY: policy_reg = cfg_data[crt_pkg::POLICY_W-1:0];
          crt_pkg::CFG_ACTIVE: active_reg = cfg_data[crt_pkg::ACTIVE_W-1:0];
          crt_pkg::CFG_SEED:   lfsr_reg = (cfg_data == '0) ? crt_pkg::LFSR_ONE : cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_lookups.push_back(predict_lookup(in_block_tag));
        tags_taken <= tags_taken + 1;
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [crt_pkg::IN_TAG_W-1:0] pool [16];
    int                           pool_n;
    logic [crt_pkg::POLICY_W-1:0] phase_policy [4];
    errors = 0;
    phase_policy = '{crt_pkg::POL_RANDOM, crt_pkg::POL_FIFO, crt_pkg::POL_LRU, POL_SPARE};

    // A small FIFO store first: fills, a FIFO hit, then the oldest goes.
    add_write(crt_pkg::CFG_ACTIVE, 16'd3);
    add_write(crt_pkg::CFG_POLICY, DAT_W'(crt_pkg::POL_FIFO));
    add_access(32'h0000_0000);
    add_access(32'hFFFF_FFFF);
    add_access(32'h0000_0000);
    add_access(32'h0000_0007);
    add_access(32'h0000_0008);
    // Active count below the held count, random victims among three, zero seed.
    add_quiesce();
    add_write(crt_pkg::CFG_ACTIVE, 16'd0);
    add_write(crt_pkg::CFG_POLICY, DAT_W'(crt_pkg::POL_RANDOM));
    add_write(crt_pkg::CFG_SEED, 16'h0000);
    add_access(32'h0000_0009);
    add_access(32'h0000_000A);
    add_access(32'h0000_000B);
    // The unused policy code with an oversized active count fills up to all slots.
    add_quiesce();
    add_write(crt_pkg::CFG_POLICY, DAT_W'(POL_SPARE));
    add_write(crt_pkg::CFG_ACTIVE, 16'd15);
    for (int t = 12; t < 17; t++) add_access(TAG_W'(t));
    add_access(32'h0000_000C);
    add_access(32'h8000_0011);
    add_quiesce();
    add_write(crt_pkg::CFG_POLICY, DAT_W'(crt_pkg::POL_LRU));
    add_write(crt_pkg::CFG_ACTIVE, 16'd8);
    add_write(crt_pkg::CFG_SEED, 16'hFFFF);
    add_write(CFG_SPARE, 16'hA5A5);
    add_access(32'h0000_0012);
    add_access(32'h0000_000D);
    add_access(32'h5555_AAAA);
    add_quiesce();
    add_write(crt_pkg::CFG_POLICY, DAT_W'(crt_pkg::POL_RANDOM));
    add_access(32'hAAAA_5555);
    add_access(32'h0000_0013);
    add_access(32'h0000_0012);

    for (int ph = 0; ph < 8; ph++) begin
      add_quiesce();
      add_write(crt_pkg::CFG_POLICY, DAT_W'(phase_policy[2'(ph % 4)]));
      add_write(crt_pkg::CFG_ACTIVE, (ph == 1) ? 16'd1 : DAT_W'($urandom_range(15)));
      add_write(crt_pkg::CFG_SEED,
                (ph % 3 == 0) ? 16'h0000 : DAT_W'($urandom_range(16'hFFFF)));
      if (ph % 2 == 0) add_write(CFG_SPARE, DAT_W'($urandom_range(16'hFFFF)));
      // A pool of six to sixteen tags, around the store size, keeps hits and evictions both common.
      pool_n = $urandom_range(6, 16);
      for (int k = 0; k < pool_n; k++) pool[k] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) < 8) add_access(pool[4'($urandom_range(pool_n - 1))]);
        else add_access($urandom);
      end
    end
    add_quiesce();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || drv_active || expected_lookups.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
